[hdl/sts_pkg.sv]
package sts_pkg;

    // Operation codes carried by one input item
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Status codes reported with each result item
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Sequencer states: take item, compare in every cell, update and emit
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_UPD  = 2'd2
    } t_state;

    // Per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;  // capture key compare flags
        logic ins;  // apply insert shift
    } t_cell_ctl;

endpackage

[hdl/sts_cell.sv]
module sts_cell #(
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  sts_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_occupied,
    input  logic                     i_first,
    input  logic [KEY_WIDTH-1:0]     i_new_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_new_payload,
    input  logic [KEY_WIDTH-1:0]     i_prev_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_prev_payload,
    input  logic                     i_prev_lt,
    output logic [KEY_WIDTH-1:0]     o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload,
    output logic                     o_lt,
    output logic                     o_eq
);
    import sts_pkg::*;

    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic                     r_lt;
    logic                     r_eq;
    logic                     n_lt;
    logic                     n_eq;

    // Compare the held record against the searched key
    always_comb begin
        n_lt = i_occupied && (r_key < i_new_key);
        n_eq = i_occupied && (r_key == i_new_key);
    end

    // Capture compare flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
    end

    // Hold below the slot, load the new record at the slot, shift up above it
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            if (i_first || i_prev_lt) begin
                r_key     <= i_new_key;
                r_payload <= i_new_payload;
            end else begin
                r_key     <= i_prev_key;
                r_payload <= i_prev_payload;
            end
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_lt      = r_lt;
    assign o_eq      = r_eq;

endmodule

[hdl/sorted_table_insert_search_top.sv]
// Channel  | valid    | stall    | payload
// ---------+----------+----------+-----------------------------------------------
// input    | i_valid  | o_stall  | i_operation, i_key, i_payload, i_index
// result   | o_valid  | i_stall  | o_position, o_found, o_key_read, o_payload_read,
//          |          |          | o_status, o_entry_count
//
// Each item passes through capture, a compare in every cell, then the
// shift/update step that also loads the result register.
// The update step waits while the result register is full and stalled, and the
// block takes no new item until it has finished the one before.
// Synchronous active-low reset empties the table (count zero); record cells are
// not cleared, and entries at or above the count are never reported.
module sorted_table_insert_search_top #(
    parameter int DEPTH         = 64,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_operation,
    input  logic [KEY_WIDTH-1:0]             i_key,
    input  logic [PAYLOAD_WIDTH-1:0]         i_payload,
    input  logic [$clog2(DEPTH)-1:0]         i_index,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [$clog2(DEPTH+1)-1:0]       o_position,
    output logic                             o_found,
    output logic [KEY_WIDTH-1:0]             o_key_read,
    output logic [PAYLOAD_WIDTH-1:0]         o_payload_read,
    output logic [1:0]                       o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_entry_count
);
    import sts_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state;
    t_state                   n_state;
    t_cell_ctl                w_ctl;
    logic                     w_out_free;
    logic                     w_load;

    logic [1:0]               r_op;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [IW-1:0]            r_index;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    logic [KEY_WIDTH-1:0]     w_cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_cell_pay [DEPTH];
    logic [DEPTH-1:0]         w_lt;
    logic [DEPTH-1:0]         w_eq;
    logic [DEPTH-1:0]         w_occ;
    logic [DEPTH-1:0]         w_slot;

    logic [CW-1:0]            w_pos;
    logic                     w_found;
    logic                     w_full;
    logic                     w_in_range;
    logic [KEY_WIDTH-1:0]     w_rd_key;
    logic [PAYLOAD_WIDTH-1:0] w_rd_pay;

    logic                     r_out_valid;
    logic [CW-1:0]            r_position;
    logic                     r_found;
    logic [KEY_WIDTH-1:0]     r_key_read;
    logic [PAYLOAD_WIDTH-1:0] r_payload_read;
    logic [1:0]               r_status;
    logic [CW-1:0]            r_entry_count;
    logic [CW-1:0]            n_position;
    logic                     n_found;
    logic [KEY_WIDTH-1:0]     n_key_read;
    logic [PAYLOAD_WIDTH-1:0] n_payload_read;
    logic [1:0]               n_status;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_in_range = ({1'b0, r_index} < r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_stall = (r_state != S_IDLE);
        w_load  = (r_state == S_UPD) && w_out_free;
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_load && (r_op == OP_INSERT) && !w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op      <= i_operation;
            r_key     <= i_key;
            r_payload <= i_payload;
            r_index   <= i_index;
        end
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CW'(g) < r_count);
        if (g == 0) begin : g_head
            sts_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_occupied     (w_occ[g]),
                .i_first        (1'b1),
                .i_new_key      (r_key),
                .i_new_payload  (r_payload),
                .i_prev_key     (r_key),
                .i_prev_payload (r_payload),
                .i_prev_lt      (1'b0),
                .o_key          (w_cell_key[g]),
                .o_payload      (w_cell_pay[g]),
                .o_lt           (w_lt[g]),
                .o_eq           (w_eq[g])
            );
            assign w_slot[g] = !w_lt[g];
        end else begin : g_body
            sts_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_occupied     (w_occ[g]),
                .i_first        (1'b0),
                .i_new_key      (r_key),
                .i_new_payload  (r_payload),
                .i_prev_key     (w_cell_key[g-1]),
                .i_prev_payload (w_cell_pay[g-1]),
                .i_prev_lt      (w_lt[g-1]),
                .o_key          (w_cell_key[g]),
                .o_payload      (w_cell_pay[g]),
                .o_lt           (w_lt[g]),
                .o_eq           (w_eq[g])
            );
            assign w_slot[g] = !w_lt[g] && w_lt[g-1];
        end
    end

    // Encode the insertion point and pick the record at the read index
    always_comb begin
        w_pos    = (w_slot == '0) ? CW'(DEPTH) : '0;
        w_found  = 1'b0;
        w_rd_key = '0;
        w_rd_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_slot[i]) begin
                w_pos = w_pos | CW'(i);
            end
            w_found = w_found | (w_slot[i] & w_eq[i]);
            if (r_index == IW'(i)) begin
                w_rd_key = w_rd_key | w_cell_key[i];
                w_rd_pay = w_rd_pay | w_cell_pay[i];
            end
        end
    end

    // Build the result
    always_comb begin
        n_position     = '0;
        n_found        = 1'b0;
        n_key_read     = '0;
        n_payload_read = '0;
        n_status       = ST_OK;
        n_count        = r_count;
        case (r_op)
            OP_INSERT: begin
                n_position = w_pos;
                n_found    = w_found;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_LOOKUP: begin
                n_position = w_pos;
                n_found    = w_found;
            end
            OP_READ: begin
                if (w_in_range) begin
                    n_key_read     = w_rd_key;
                    n_payload_read = w_rd_pay;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Advance count and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_position     <= n_position;
            r_found        <= n_found;
            r_key_read     <= n_key_read;
            r_payload_read <= n_payload_read;
            r_status       <= n_status;
            r_entry_count  <= n_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_position     = r_position;
    assign o_found        = r_found;
    assign o_key_read     = r_key_read;
    assign o_payload_read = r_payload_read;
    assign o_status       = r_status;
    assign o_entry_count  = r_entry_count;

endmodule

[hdl/sts_check.sv]
module sts_check #(
    parameter int DEPTH         = 64,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       o_stall,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  logic [$clog2(DEPTH+1)-1:0] o_position,
    input  logic [KEY_WIDTH-1:0]       o_key_read,
    input  logic [PAYLOAD_WIDTH-1:0]   o_payload_read,
    input  logic [1:0]                 o_status,
    input  logic [$clog2(DEPTH+1)-1:0] o_entry_count
);
    import sts_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // A stalled result holds its position
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position))
        else $error("result changed while stalled");

    // One item at a time: the block is busy right after accepting
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted a second item without a busy cycle");

    // The count never exceeds the table depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // A full report comes only with a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == CW'(DEPTH))
        else $error("full status with free space");

    // An out-of-range read returns an empty record
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_RANGE |-> o_key_read == '0 && o_payload_read == '0)
        else $error("out-of-range read returned data");

endmodule

bind sorted_table_insert_search_top sts_check #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_sts_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_position     (o_position),
    .o_key_read     (o_key_read),
    .o_payload_read (o_payload_read),
    .o_status       (o_status),
    .o_entry_count  (o_entry_count)
);

[tb/sorted_table_insert_search_checker.sv]
`timescale 1ns / 100ps

module sorted_table_insert_search_checker #(
    parameter int DEPTH         = 64,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [PAYLOAD_WIDTH-1:0]     i_payload,
    input  logic [$clog2(DEPTH)-1:0]     i_index,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [$clog2(DEPTH+1)-1:0]   i_position,
    input  logic                         i_found,
    input  logic [KEY_WIDTH-1:0]         i_key_read,
    input  logic [PAYLOAD_WIDTH-1:0]     i_payload_read,
    input  logic [1:0]                   i_status,
    input  logic [$clog2(DEPTH+1)-1:0]   i_entry_count,
    output int                           o_error_count,
    output int                           o_pending
);
    import sts_pkg::*;

    localparam int POS_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic                     found;
        logic [KEY_WIDTH-1:0]     key_read;
        logic [PAYLOAD_WIDTH-1:0] payload_read;
        t_status                  status;
        logic [POS_W-1:0]         entry_count;
    } t_table_result;

    // Shadow copy of the sorted table
    logic [KEY_WIDTH-1:0]     shadow_keys     [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] shadow_payloads [DEPTH];
    int                       records_held;

    t_table_result            expected_results [$];
    int                       error_count = 0;
    int                       pending_count = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending_count;

    // Apply one item to the shadow table and return the result it gives
    function automatic t_table_result apply_table_item(
        input logic [1:0]                 op,
        input logic [KEY_WIDTH-1:0]       k,
        input logic [PAYLOAD_WIDTH-1:0]   pl,
        input logic [$clog2(DEPTH)-1:0]   idx
    );
        t_table_result r;
        int            slot;
        r    = '0;
        slot = 0;
        if (op == OP_INSERT || op == OP_LOOKUP) begin
            // lowest slot whose key is not below k
            while (slot < records_held && shadow_keys[slot] < k)
                slot++;
            r.position = POS_W'(slot);
            r.found    = (slot < records_held) && (shadow_keys[slot] == k);
            if (op == OP_INSERT) begin
                if (records_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = records_held; j > slot; j--) begin
                        shadow_keys[j]     = shadow_keys[j-1];
                        shadow_payloads[j] = shadow_payloads[j-1];
                    end
                    shadow_keys[slot]     = k;
                    shadow_payloads[slot] = pl;
                    records_held++;
                end
            end
        end else if (op == OP_READ) begin
            if (int'(idx) < records_held) begin
                r.key_read     = shadow_keys[idx];
                r.payload_read = shadow_payloads[idx];
            end else begin
                r.status = ST_RANGE;
            end
        end
        // the unused code leaves everything but the count at zero
        r.entry_count = POS_W'(records_held);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each result item with the oldest prediction, then predict new items
    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            records_held = 0;
            expected_results.delete();
            pending_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no item outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("position", want.position, i_position);
                    check_field("found", want.found, i_found);
                    check_field("key_read", want.key_read, i_key_read);
                    check_field("payload_read", want.payload_read, i_payload_read);
                    check_field("status", want.status, i_status);
                    check_field("entry_count", want.entry_count, i_entry_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(
                    apply_table_item(i_operation, i_key, i_payload, i_index));
            pending_count = expected_results.size();
        end
    end

endmodule

[tb/tb_sorted_table_insert_search_top.sv]
`timescale 1ns / 100ps

module tb_sorted_table_insert_search_top;
    import sts_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         RANDOM_ITEMS    = 1580;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         IDLE_LIMIT      = 4000;
    localparam int         DRAIN_CYCLES    = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] payload;
    logic [5:0]  index;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  position;
    logic        found;
    logic [31:0] key_read;
    logic [31:0] payload_read;
    logic [1:0]  status;
    logic [6:0]  entry_count;

    int          err_count;
    int          results_pending;
    int          send_idle_pct = 14;
    int          recv_idle_pct = 78;
    bit          hold_off_req  = 1'b0;
    logic [31:0] inserted_keys [$];

    sorted_table_insert_search_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_operation    (operation),
        .i_key          (key),
        .i_payload      (payload),
        .i_index        (index),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_position     (position),
        .o_found        (found),
        .o_key_read     (key_read),
        .o_payload_read (payload_read),
        .o_status       (status),
        .o_entry_count  (entry_count)
    );

    sorted_table_insert_search_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (operation),
        .i_key          (key),
        .i_payload      (payload),
        .i_index        (index),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_position     (position),
        .i_found        (found),
        .i_key_read     (key_read),
        .i_payload_read (payload_read),
        .i_status       (status),
        .i_entry_count  (entry_count),
        .o_error_count  (err_count),
        .o_pending      (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, with a random gap first; return at the falling edge after it is taken
    task automatic send_item(input logic [1:0] op, input logic [31:0] k,
                             input logic [31:0] pl, input logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        payload   <= pl;
        index     <= idx;
        if (op == OP_INSERT)
            inserted_keys.push_back(k);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Favor keys already in the table, then the extremes, then anything
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        if (roll < 55) begin
            case ($urandom_range(5))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h8000_0000;
                4:       return 32'hFFFF_FFFE;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Receiver: random stall, plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial begin
        int          roll;
        int          held;
        logic [1:0]  op;
        logic [5:0]  idx;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_INSERT;
        key       = '0;
        payload   = '0;
        index     = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: lookup, reads beyond count
        send_item(OP_LOOKUP, 32'h0000_0000, 32'h0, 6'd0);
        send_item(OP_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_READ,   32'h0, 32'h0, 6'd63);
        // extremes and a duplicate going in front of its equal
        send_item(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 6'd0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 6'd21);
        send_item(OP_INSERT, 32'h8000_0000, 32'h0000_1234, 6'd42);
        send_item(OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 6'd0);
        // hits, misses and insertion points
        send_item(OP_LOOKUP, 32'h8000_0000, 32'h0, 6'd0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 6'd0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 6'd0);
        send_item(OP_LOOKUP, 32'h0000_0001, 32'h0, 6'd0);
        // read every record, then the first index past the count
        for (int i = 0; i < 6; i++)
            send_item(OP_READ, $urandom, $urandom, 6'(i));
        // unused code
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_UNUSED, 32'h0, 32'h0, 6'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 14;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver hold-off while items keep coming
            if (n == 100)
                hold_off_req = 1'b1;
            // hold input until the block has drained
            if (n == RANDOM_ITEMS / 2) begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (results_pending != 0)
                    @(negedge clk);
            end

            roll = $urandom_range(99);
            if (roll < 10)
                op = OP_INSERT;
            else if (roll < 45)
                op = OP_LOOKUP;
            else if (roll < 90)
                op = OP_READ;
            else
                op = OP_UNUSED;

            held = (inserted_keys.size() > 64) ? 64 : inserted_keys.size();
            if ($urandom_range(99) < 60 && held > 0)
                idx = 6'($urandom_range(held - 1));
            else
                idx = 6'($urandom_range(63));

            send_item(op, pick_key(), $urandom, idx);
        end
        in_valid <= 1'b0;

        // drain outstanding results, then allow for the pipeline
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
